FILE: design/lht_pkg.sv
package lht_pkg;

  // Default build values
  localparam int LHT_MAX_TOKEN_LEN = 65535;
  localparam int LHT_WORD_SLOTS    = 8;

  localparam int LEN_W     = 16;
  localparam int CHAR_W    = 16;
  // Longest word in the list; the classifier looks at this many slots
  localparam int CMP_CHARS = 8;

  typedef enum logic [3:0] {
    CL_DEF  = 4'd0,
    CL_LCOM = 4'd1,
    CL_BCOM = 4'd2,
    CL_PREP = 4'd3,
    CL_STR  = 4'd4,
    CL_NUM  = 4'd5,
    CL_SELF = 4'd6,
    CL_KEY  = 4'd7,
    CL_SPEC = 4'd8
  } tok_class_t;

  // One highlight token
  typedef struct packed {
    tok_class_t         cls;
    logic [LEN_W-1:0]   len;
    logic               last;
  } tok_t;

  // Tokens caused by one character: up to two, in order
  typedef struct packed {
    logic [1:0] count;
    tok_t       r0;
    tok_t       r1;
  } step_out_t;

  // Word list, text right-justified in 8-bit characters
  typedef struct packed {
    logic [3:0]  n;
    logic [63:0] text;
    tok_class_t  cls;
  } word_entry_t;

  localparam int N_WORDS = 23;

  localparam word_entry_t WORD_LIST [N_WORDS] = '{
    '{4'd4, 64'("true"),     CL_NUM},
    '{4'd5, 64'("false"),    CL_NUM},
    '{4'd3, 64'("nil"),      CL_NUM},
    '{4'd4, 64'("self"),     CL_SELF},
    '{4'd3, 64'("and"),      CL_KEY},
    '{4'd5, 64'("break"),    CL_KEY},
    '{4'd5, 64'("const"),    CL_KEY},
    '{4'd2, 64'("do"),       CL_KEY},
    '{4'd4, 64'("else"),     CL_KEY},
    '{4'd6, 64'("elseif"),   CL_KEY},
    '{4'd3, 64'("end"),      CL_KEY},
    '{4'd3, 64'("for"),      CL_KEY},
    '{4'd8, 64'("function"), CL_KEY},
    '{4'd2, 64'("if"),       CL_KEY},
    '{4'd5, 64'("local"),    CL_KEY},
    '{4'd3, 64'("not"),      CL_KEY},
    '{4'd2, 64'("or"),       CL_KEY},
    '{4'd6, 64'("repeat"),   CL_KEY},
    '{4'd6, 64'("return"),   CL_KEY},
    '{4'd4, 64'("then"),     CL_KEY},
    '{4'd5, 64'("until"),    CL_KEY},
    '{4'd5, 64'("while"),    CL_KEY},
    '{4'd6, 64'("assert"),   CL_SPEC}
  };

  // Class of a finished word; parallel compare against every list entry
  function automatic tok_class_t lht_word_class(
    input logic [CMP_CHARS-1:0][CHAR_W-1:0] chars,
    input logic [LEN_W-1:0]                 len,
    input logic                             ovf
  );
    tok_class_t  cls;
    logic [63:0] t;
    logic        hit;
    cls = CL_DEF;
    for (int k = 0; k < N_WORDS; k++) begin
      // left-justify so character i sits at a fixed place
      t   = WORD_LIST[k].text << (8 * (8 - int'(WORD_LIST[k].n)));
      hit = !ovf && (len == LEN_W'(WORD_LIST[k].n));
      for (int i = 0; i < CMP_CHARS; i++) begin
        if ((i < int'(WORD_LIST[k].n)) && (chars[i] != {8'h00, t[63-8*i -: 8]})) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        cls = WORD_LIST[k].cls;
      end
    end
    return cls;
  endfunction

endpackage

FILE: design/lht_core.sv
module lht_core
  import lht_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = LHT_MAX_TOKEN_LEN,
  parameter int WORD_SLOTS    = LHT_WORD_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic [CHAR_W-1:0] ch,
  input  logic              text_end,
  output step_out_t         res
);

  localparam int IDX_W = $clog2(WORD_SLOTS);

  localparam logic [CHAR_W-1:0] CH_LBRK  = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_RBRK  = 16'h005D;
  localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_HASH  = 16'h0023;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;

  typedef enum logic [3:0] {
    M_IDLE,
    M_BC_BRK,
    M_DASH1,
    M_DASH2,
    M_DASH3,
    M_LCOM,
    M_PREP,
    M_STR,
    M_NUM,
    M_WORD
  } mode_t;

  // One emission slot: transition, fresh start, text-end flush
  typedef struct packed {
    logic             v;
    tok_class_t       cls;
    logic [LEN_W-1:0] len;
  } emit_t;

  function automatic logic is_nl(input logic [CHAR_W-1:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return c inside {16'h0020, 16'h002E, 16'h002C, 16'h003A, 16'h003B, 16'h0028,
                     16'h0029, 16'h005B, 16'h005D, 16'h007B, 16'h007D, 16'h002B,
                     16'h002D, 16'h002A, 16'h002F, 16'h0025, 16'h007E, 16'h003D,
                     16'h003C, 16'h003E, 16'h0009, 16'h000A, 16'h000D};
  endfunction

  mode_t                  mode, mode_next;
  logic                   bc, bc_next;
  logic [LEN_W-1:0]       len, len_next;
  logic                   ovf, ovf_next;
  logic [CHAR_W-1:0]      word_chars [WORD_SLOTS];

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic                   start;
  logic [LEN_W:0]         len_inc;
  logic                   grow_hit;
  tok_class_t             run_cls;
  emit_t                  e0, e1, e2;
  logic [CMP_CHARS-1:0][CHAR_W-1:0] chars_cur, chars_n;

  assign len_inc  = {1'b0, len} + (LEN_W+1)'(1);
  assign grow_hit = len_inc >= (LEN_W+1)'(MAX_TOKEN_LEN);
  assign run_cls  = (mode == M_LCOM) ? CL_LCOM :
                    (mode == M_PREP) ? CL_PREP :
                    (mode == M_STR)  ? CL_STR  :
                    (mode == M_NUM)  ? CL_NUM  : CL_DEF;

  always_comb begin
    for (int i = 0; i < CMP_CHARS; i++) begin
      chars_cur[i] = word_chars[i];
    end
  end

  // Next state and the tokens caused by this character
  always_comb begin
    mode_next = mode;
    bc_next   = bc;
    len_next  = len;
    ovf_next  = ovf;
    wr_en     = 1'b0;
    wr_idx    = '0;
    start     = 1'b0;
    e0        = '0;
    e1        = '0;
    e2        = '0;

    case (mode)
      M_BC_BRK: begin
        if (ch == CH_RBRK) begin
          e0        = '{1'b1, CL_BCOM, LEN_W'(2)};
          bc_next   = 1'b0;
          mode_next = M_IDLE;
          len_next  = '0;
        end else begin
          e0    = '{1'b1, CL_BCOM, LEN_W'(1)};
          start = 1'b1;
        end
      end
      M_DASH1: begin
        if (ch == CH_DASH) begin
          mode_next = M_DASH2;
          len_next  = LEN_W'(2);
        end else begin
          e0    = '{1'b1, CL_DEF, LEN_W'(1)};
          start = 1'b1;
        end
      end
      M_DASH2, M_DASH3: begin
        if (ch == CH_LBRK && mode == M_DASH3) begin
          bc_next   = 1'b1;
          e0        = '{1'b1, CL_BCOM, LEN_W'(4)};
          mode_next = M_IDLE;
          len_next  = '0;
        end else if (ch == CH_LBRK) begin
          mode_next = M_DASH3;
          len_next  = LEN_W'(3);
        end else if (is_nl(ch)) begin
          e0    = '{1'b1, CL_LCOM, len};
          start = 1'b1;
        end else begin
          mode_next = M_LCOM;
          if (grow_hit) begin
            e0       = '{1'b1, CL_LCOM, len_inc[LEN_W-1:0]};
            len_next = '0;
          end else begin
            len_next = len_inc[LEN_W-1:0];
          end
        end
      end
      M_LCOM, M_PREP, M_STR, M_NUM: begin
        if ((mode == M_STR) && (ch == CH_QUOTE)) begin
          // closing quote belongs to the string
          e0        = '{1'b1, CL_STR, len_inc[LEN_W-1:0]};
          mode_next = M_IDLE;
          len_next  = '0;
        end else if (((mode == M_LCOM || mode == M_PREP) && is_nl(ch)) ||
                     ((mode == M_NUM) && !is_digit(ch) && (ch != CH_DOT))) begin
          e0    = '{len != '0, run_cls, len};
          start = 1'b1;
        end else if (grow_hit) begin
          e0       = '{1'b1, run_cls, len_inc[LEN_W-1:0]};
          len_next = '0;
        end else begin
          len_next = len_inc[LEN_W-1:0];
        end
      end
      M_WORD: begin
        if (is_delim(ch)) begin
          e0    = '{len != '0, lht_word_class(chars_cur, len, ovf), len};
          start = 1'b1;
        end else begin
          if (!ovf && ({1'b0, len} < (LEN_W+1)'(WORD_SLOTS))) begin
            wr_en  = 1'b1;
            wr_idx = len[IDX_W-1:0];
          end else begin
            ovf_next = 1'b1;
          end
          if (grow_hit) begin
            e0       = '{1'b1, CL_DEF, len_inc[LEN_W-1:0]};
            len_next = '0;
            ovf_next = 1'b1;
          end else begin
            len_next = len_inc[LEN_W-1:0];
          end
        end
      end
      default: begin
        start = 1'b1;
      end
    endcase

    // Character with nothing pending
    if (start) begin
      mode_next = M_IDLE;
      len_next  = '0;
      if (bc) begin
        if (ch == CH_RBRK) begin
          mode_next = M_BC_BRK;
          len_next  = LEN_W'(1);
        end else begin
          e1 = '{1'b1, CL_BCOM, LEN_W'(1)};
        end
      end else if (ch == CH_DASH) begin
        mode_next = M_DASH1;
        len_next  = LEN_W'(1);
      end else if (ch == CH_HASH) begin
        mode_next = M_PREP;
        len_next  = LEN_W'(1);
      end else if (ch == CH_QUOTE) begin
        mode_next = M_STR;
        len_next  = LEN_W'(1);
      end else if (is_digit(ch)) begin
        mode_next = M_NUM;
        len_next  = LEN_W'(1);
      end else if (is_delim(ch)) begin
        e1 = '{1'b1, CL_DEF, LEN_W'(1)};
      end else begin
        mode_next = M_WORD;
        ovf_next  = 1'b0;
        wr_en     = 1'b1;
        wr_idx    = '0;
        len_next  = LEN_W'(1);
      end
    end

    // Word characters as they stand after this write
    for (int i = 0; i < CMP_CHARS; i++) begin
      chars_n[i] = (wr_en && (wr_idx == IDX_W'(i))) ? ch : word_chars[i];
    end

    // End of text flushes whatever is pending
    if (text_end) begin
      case (mode_next)
        M_BC_BRK: e2 = '{1'b1, CL_BCOM, LEN_W'(1)};
        M_DASH1:  e2 = '{1'b1, CL_DEF, LEN_W'(1)};
        M_DASH2, M_DASH3, M_LCOM:
                  e2 = '{len_next != '0, CL_LCOM, len_next};
        M_PREP:   e2 = '{len_next != '0, CL_PREP, len_next};
        M_STR:    e2 = '{len_next != '0, CL_STR, len_next};
        M_NUM:    e2 = '{len_next != '0, CL_NUM, len_next};
        M_WORD:   e2 = '{len_next != '0, lht_word_class(chars_n, len_next, ovf_next),
                         len_next};
        default:  e2 = '0;
      endcase
      mode_next = M_IDLE;
      len_next  = '0;
    end
  end

  // Pack the first two emissions in order, mark the final one
  always_comb begin
    res = '0;
    if (e0.v) begin
      res.r0 = '{e0.cls, e0.len, 1'b0};
      if (e1.v) begin
        res.r1    = '{e1.cls, e1.len, 1'b0};
        res.count = 2'd2;
      end else if (e2.v) begin
        res.r1    = '{e2.cls, e2.len, 1'b0};
        res.count = 2'd2;
      end else begin
        res.count = 2'd1;
      end
    end else if (e1.v) begin
      res.r0 = '{e1.cls, e1.len, 1'b0};
      if (e2.v) begin
        res.r1    = '{e2.cls, e2.len, 1'b0};
        res.count = 2'd2;
      end else begin
        res.count = 2'd1;
      end
    end else if (e2.v) begin
      res.r0    = '{e2.cls, e2.len, 1'b0};
      res.count = 2'd1;
    end
    if (res.count == 2'd2) begin
      res.r1.last = 1'b1;
    end else if (res.count == 2'd1) begin
      res.r0.last = 1'b1;
    end
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      bc   <= 1'b0;
      len  <= '0;
      ovf  <= 1'b0;
    end else if (valid) begin
      mode <= mode_next;
      bc   <= bc_next;
      len  <= len_next;
      ovf  <= ovf_next;
    end
  end

  // Leading characters of the pending word
  always_ff @(posedge clk) begin
    if (valid && wr_en) begin
      word_chars[wr_idx] <= ch;
    end
  end

`ifndef SYNTHESIS
  a_len_below_max: assert property (@(posedge clk) disable iff (rst)
    {1'b0, len} < (LEN_W+1)'(MAX_TOKEN_LEN))
    else $error("pending length reached the maximum");

  a_bc_entry: assert property (@(posedge clk) disable iff (rst)
    valid && !bc && bc_next |-> (mode == M_DASH3) && (ch == CH_LBRK))
    else $error("block comment entered without opening bracket pair");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    valid && (res.count == 2'd1) |-> res.r0.last)
    else $error("single token not marked last");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    valid && (res.count == 2'd2) |-> !res.r0.last && res.r1.last)
    else $error("token pair marked wrongly");
`endif

endmodule

FILE: design/lua_highlight_tokenizer.sv
// Lua highlight tokenizer. Takes one UTF-16 code unit per item (s_tlast marks the last
// character of a text) and returns highlight tokens, each a class and a length, as soon
// as each token's end is known; m_tlast marks the last token caused by one character.
// A new character is taken every cycle while the result queue has room for two more
// tokens. A character that closes two tokens puts two items into the four-entry result
// queue, which drains one token per cycle while m_tready is high, so a burst of such
// characters can fill the queue and stall the input. An item passes the input register,
// then the lexer step that writes the queue. Block-comment state survives a text end and
// is cleared by reset or a closing ]]. No clearing pass is needed after reset.
module lua_highlight_tokenizer
  import lht_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = LHT_MAX_TOKEN_LEN,
  parameter int WORD_SLOTS    = LHT_WORD_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] char_code
  input  logic        s_tlast,   // text_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] token_length
  output logic [3:0]  m_tuser,   // [3:0] token_class
  output logic        m_tlast    // run_last
);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_end;
  logic              proc;
  logic              pop;
  step_out_t         res;

  tok_t              q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_AW:0]     count, count_next;

  // Step runs when the queue has room for two more tokens
  assign proc     = in_valid && (count <= (Q_AW+1)'(Q_DEPTH - 2));
  assign s_tready = !in_valid || proc;
  assign pop      = m_tvalid && m_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  lht_core #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .WORD_SLOTS    (WORD_SLOTS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .valid    (proc),
    .ch       (in_char),
    .text_end (in_end),
    .res      (res)
  );

  // Result queue
  assign count_next = count + (proc ? (Q_AW+1)'(res.count) : '0)
                            - (Q_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + Q_AW'(res.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (res.count != 2'd0)) begin
      q[wr_ptr] <= res.r0;
    end
    if (proc && (res.count == 2'd2)) begin
      q[wr_ptr + Q_AW'(1)] <= res.r1;
    end
  end

  assign m_tvalid = count != '0;
  assign m_tdata  = q[rd_ptr].len;
  assign m_tuser  = q[rd_ptr].cls;
  assign m_tlast  = q[rd_ptr].last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("result queue overfilled");

  a_q_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !proc |=> count == $past(count) - (Q_AW+1)'(1))
    else $error("result queue count lost track of a pop");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc |=> in_valid && $stable(in_char) && $stable(in_end))
    else $error("waiting input item changed");
`endif

endmodule

FILE: verif/tb_lua_highlight_tokenizer.sv
`timescale 1ns / 100ps

module tb_lua_highlight_tokenizer;
  import lht_pkg::*;

  localparam int MAX_LEN = LHT_MAX_TOKEN_LEN;
  localparam int SLOTS   = LHT_WORD_SLOTS;

  // Tracks the lexer state of the block and the tokens still owed by it
  class token_scoreboard;
    typedef enum int {
      LX_IDLE, LX_BC_BRK, LX_DASH1, LX_DASH2, LX_DASH3,
      LX_LCOM, LX_PREP, LX_STR, LX_NUM, LX_WORD
    } lex_mode_t;

    lex_mode_t   mode = LX_IDLE;
    bit          in_bc = 1'b0;
    int unsigned run_len = 0;
    logic [15:0] word_buf [SLOTS];
    bit          word_ovf = 1'b0;
    tok_t        step_toks [$];
    tok_t        pending_tokens [$];
    int          errors = 0;

    function bit is_nl(logic [15:0] c);
      return c == 16'h000A || c == 16'h000D;
    endfunction

    function bit is_digit(logic [15:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_delim(logic [15:0] c);
      case (c)
        " ", ".", ",", ":", ";", "(", ")", "[", "]", "{", "}", "+", "-", "*", "/",
        "%", "~", "=", "<", ">", "\t", "\n", "\r": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // at most two tokens per character
    function void emit_token(tok_class_t c, int unsigned n);
      tok_t t;
      if (step_toks.size() < 2) begin
        t.cls  = c;
        t.len  = 16'(n);
        t.last = 1'b0;
        step_toks = {step_toks, t};
      end
    endfunction

    // class of a finished word, from its stored characters
    function tok_class_t word_kind();
      string s = "";
      if (word_ovf || run_len > SLOTS) return CL_DEF;
      for (int i = 0; i < run_len; i++) begin
        if (word_buf[i] == 16'h0000 || word_buf[i] > 16'h007F) return CL_DEF;
        s = $sformatf("%s%c", s, word_buf[i][7:0]);
      end
      case (s)
        "true", "false", "nil": return CL_NUM;
        "self": return CL_SELF;
        "and", "break", "const", "do", "else", "elseif", "end", "for", "function",
        "if", "local", "not", "or", "repeat", "return", "then", "until",
        "while": return CL_KEY;
        "assert": return CL_SPEC;
        default: return CL_DEF;
      endcase
    endfunction

    function void close_run(tok_class_t c);
      if (run_len > 0) emit_token(c, run_len);
      run_len = 0;
      mode = LX_IDLE;
    endfunction

    // a run at full length goes out at once and the class carries on
    function void grow_run(tok_class_t c);
      run_len++;
      if (run_len >= MAX_LEN) begin
        emit_token(c, run_len);
        run_len = 0;
        if (mode == LX_WORD) word_ovf = 1'b1;
      end
    endfunction

    // character seen with nothing pending
    function void start_token(logic [15:0] c);
      mode = LX_IDLE;
      run_len = 0;
      if (in_bc) begin
        if (c == "]") begin
          mode = LX_BC_BRK;
          run_len = 1;
        end else begin
          emit_token(CL_BCOM, 1);
        end
      end else if (c == "-") begin
        mode = LX_DASH1;
        run_len = 1;
      end else if (c == "#") begin
        mode = LX_PREP;
        run_len = 1;
      end else if (c == "\"") begin
        mode = LX_STR;
        run_len = 1;
      end else if (is_digit(c)) begin
        mode = LX_NUM;
        run_len = 1;
      end else if (is_delim(c)) begin
        emit_token(CL_DEF, 1);
      end else begin
        mode = LX_WORD;
        word_ovf = 1'b0;
        word_buf[0] = c;
        run_len = 0;
        grow_run(CL_DEF);
      end
    endfunction

    // end of text: whatever is pending goes out
    function void flush_pending();
      case (mode)
        LX_BC_BRK: emit_token(CL_BCOM, 1);
        LX_DASH1: emit_token(CL_DEF, 1);
        LX_DASH2, LX_DASH3, LX_LCOM: close_run(CL_LCOM);
        LX_PREP: close_run(CL_PREP);
        LX_STR: close_run(CL_STR);
        LX_NUM: close_run(CL_NUM);
        LX_WORD: if (run_len > 0) emit_token(word_kind(), run_len);
        default: ;
      endcase
      mode = LX_IDLE;
      run_len = 0;
    endfunction

    // accepted character: work out the tokens it releases
    function void note_char(logic [15:0] c, logic text_end);
      tok_class_t run_cls;
      step_toks.delete();
      case (mode)
        LX_BC_BRK: begin
          if (c == "]") begin
            emit_token(CL_BCOM, 2);
            in_bc = 1'b0;
            mode = LX_IDLE;
            run_len = 0;
          end else begin
            emit_token(CL_BCOM, 1);
            start_token(c);
          end
        end
        LX_DASH1: begin
          if (c == "-") begin
            mode = LX_DASH2;
            run_len = 2;
          end else begin
            emit_token(CL_DEF, 1);
            start_token(c);
          end
        end
        LX_DASH2, LX_DASH3: begin
          if (c == "[" && mode == LX_DASH3) begin
            in_bc = 1'b1;
            emit_token(CL_BCOM, 4);
            mode = LX_IDLE;
            run_len = 0;
          end else if (c == "[") begin
            mode = LX_DASH3;
            run_len = 3;
          end else if (is_nl(c)) begin
            close_run(CL_LCOM);
            start_token(c);
          end else begin
            mode = LX_LCOM;
            grow_run(CL_LCOM);
          end
        end
        LX_LCOM, LX_PREP: begin
          run_cls = (mode == LX_LCOM) ? CL_LCOM : CL_PREP;
          if (is_nl(c)) begin
            close_run(run_cls);
            start_token(c);
          end else begin
            grow_run(run_cls);
          end
        end
        LX_STR: begin
          if (c == "\"") begin
            run_len++;
            close_run(CL_STR);
          end else begin
            grow_run(CL_STR);
          end
        end
        LX_NUM: begin
          if (is_digit(c) || c == ".") begin
            grow_run(CL_NUM);
          end else begin
            close_run(CL_NUM);
            start_token(c);
          end
        end
        LX_WORD: begin
          if (is_delim(c)) begin
            if (run_len > 0) emit_token(word_kind(), run_len);
            start_token(c);
          end else begin
            if (!word_ovf && run_len < SLOTS) word_buf[run_len] = c;
            else word_ovf = 1'b1;
            grow_run(CL_DEF);
          end
        end
        default: start_token(c);
      endcase
      if (text_end) flush_pending();
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      pending_tokens = {pending_tokens, step_toks};
    endfunction

    // compare one output token against the oldest one owed
    function void check_token(logic [3:0] cls, logic [15:0] len, logic last_flag);
      tok_t want;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: class %0d length %0d", cls, len);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      if (cls !== want.cls) begin
        $error("token_class: expected %0d, got %0d", want.cls, cls);
        errors++;
      end
      if (len !== want.len) begin
        $error("token_length: expected %0d, got %0d", want.len, len);
        errors++;
      end
      if (last_flag !== want.last) begin
        $error("run_last: expected %0d, got %0d", want.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  token_scoreboard sb = new();

  logic [15:0] text_buf [$];
  int          burst_left = 0;
  int          chars_sent = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_tick = 0;

  string lua_words [23] = '{
    "true", "false", "nil", "self", "and", "break", "const", "do", "else", "elseif",
    "end", "for", "function", "if", "local", "not", "or", "repeat", "return", "then",
    "until", "while", "assert"
  };
  string delim_chars = " .,:;()[]{}+-*/%~=<>\t\n\r";
  string id_chars    = "abcdefghijklmnopqrstuvwxyzABCXYZ_0123456789";

  lua_highlight_tokenizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: stall pattern, one of four, is redrawn whenever its random countdown runs out
  always @(posedge clk) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (rx_tick % 8 == 0);
      default: m_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // token monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_token(m_tuser, m_tdata, m_tlast);
  end

  // one character, with the sender's burst and gap pattern
  task automatic push_char(input logic [15:0] c, input logic text_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= text_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_char(c, text_end);
    chars_sent++;
  endtask

  task automatic add_code(input logic [15:0] c);
    text_buf = {text_buf, c};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf = {text_buf, 16'(s[i])};
  endtask

  // send the buffered text; text end on the last character and, as noise, anywhere
  task automatic send_text(input bit end_last, input bit noisy);
    logic e;
    for (int i = 0; i < text_buf.size(); i++) begin
      e = (end_last && i == text_buf.size() - 1) || (noisy && $urandom_range(0, 79) == 0);
      push_char(text_buf[i], e);
    end
    text_buf.delete();
  endtask

  // hold the sender until every owed token has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_tokens.size() != 0);
  endtask

  function automatic logic [15:0] pick_delim();
    return 16'(delim_chars[$urandom_range(0, delim_chars.len() - 1)]);
  endfunction

  function automatic logic [15:0] rand_text_char();
    case ($urandom_range(0, 15))
      0: return 16'h000A;
      1: return 16'($urandom_range(0, 65535));
      2: return "]";
      default: return 16'($urandom_range(32, 126));
    endcase
  endfunction

  // one piece of Lua-like source text
  task automatic add_fragment();
    int    kind;
    int    n;
    string w;
    if (sb.in_bc && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(0, 4)) add_code(rand_text_char());
      add_text("]]");
      return;
    end
    kind = $urandom_range(0, 15);
    case (kind)
      0, 13, 15: begin
        add_text(lua_words[$urandom_range(0, 22)]);
        add_code(pick_delim());
      end
      1: begin
        // near misses of listed words
        w = lua_words[$urandom_range(0, 22)];
        n = $urandom_range(0, 2);
        if (n == 0) w = {w, "_"};
        if (n == 1) w = w.substr(0, w.len() - 2);
        for (int i = 0; i < w.len(); i++) begin
          if (n == 2 && i == 0) add_code(16'h0100 | 16'(w[i]));
          else add_code(16'(w[i]));
        end
        add_code(pick_delim());
      end
      2, 14: begin
        n = $urandom_range(1, 12);
        add_code(16'(id_chars[$urandom_range(0, id_chars.len() - 11)]));
        for (int i = 1; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) add_code(16'($urandom_range(128, 65535)));
          else add_code(16'(id_chars[$urandom_range(0, id_chars.len() - 1)]));
        end
        add_code(pick_delim());
      end
      3: begin
        add_code(16'($urandom_range("0", "9")));
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) add_code(".");
          else add_code(16'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 3) == 0) add_code("e");
        else add_code(pick_delim());
      end
      4: begin
        add_code("\"");
        repeat ($urandom_range(0, 10)) add_code(rand_text_char());
        if ($urandom_range(0, 4) != 0) add_code("\"");
      end
      5: begin
        add_text("--");
        repeat ($urandom_range(0, 10)) add_code(16'($urandom_range(32, 126)));
        add_code($urandom_range(0, 1) ? 16'h000A : 16'h000D);
      end
      6: begin
        add_text("--[[");
        repeat ($urandom_range(0, 8)) add_code(rand_text_char());
        add_text("]]");
      end
      7: begin
        add_code("#");
        repeat ($urandom_range(0, 10)) add_code(16'($urandom_range(32, 126)));
        add_code("\n");
      end
      8: add_code(pick_delim());
      9: begin
        case ($urandom_range(0, 2))
          0: add_code(" ");
          1: add_code("\t");
          default: add_code("\n");
        endcase
      end
      10: begin
        // dash forms: lone dash, comment cut short
        case ($urandom_range(0, 3))
          0: add_text("-a");
          1: add_text("--\n");
          2: add_text("--[\r");
          default: add_text("--[a\n");
        endcase
      end
      11: repeat ($urandom_range(1, 4)) add_code(16'($urandom_range(0, 65535)));
      default: begin
        if ($urandom_range(0, 1) == 1) add_text("]]");
        else add_code("]");
      end
    endcase
  endtask

  initial begin
    int next_drain;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: block comment across a text end, its close, dash and comment cases
    add_text("--[[]");
    send_text(1'b1, 1'b0);
    add_text("x]]-#\n--\n");
    send_text(1'b0, 1'b0);
    add_text("--[");
    send_text(1'b1, 1'b0);
    add_text("\"a");
    send_text(1'b1, 1'b0);
    add_code(16'hFFFF);
    add_code(16'h0000);
    send_text(1'b1, 1'b0);
    add_text("self(");
    send_text(1'b0, 1'b0);
    wait_drained();

    // random source text
    next_drain = chars_sent + 400;
    while (chars_sent < 1700) begin
      add_fragment();
      if ($urandom_range(0, 9) == 0) add_code(" ");
      send_text($urandom_range(0, 7) == 0, 1'b1);
      if (chars_sent >= next_drain) begin
        wait_drained();
        next_drain = chars_sent + 400;
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
